>>> sv/kmsl_pkg.sv
// Shared types, constants and helpers for the keyed multimap lookup core.
package kmsl_pkg;

  localparam int NUM_KEYS  = 175760;
  localparam int KEY_W     = 18;
  localparam int CHAR_W    = 8;
  localparam int IN_VAL_W  = 12;
  localparam int OUT_VAL_W = 12;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W  = 2;

  localparam int RADIX_L = 26;
  localparam int RADIX_D = 10;

  localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_NAME = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]     key_index;
    logic [CNT_OUT_W-1:0] entry_count;
    logic [OUT_VAL_W-1:0] value;
    logic                 has_value;
    logic                 last_of_run;
    logic [STATUS_W-1:0]  status;
  } res_t;

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_A) && (c < CHAR_A + CHAR_W'(RADIX_L));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CHAR_ZERO) && (c < CHAR_ZERO + CHAR_W'(RADIX_D));
  endfunction

endpackage

>>> sv/kmsl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module kmsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/kmsl_ctrl.sv
// Sequencer: name packing, sorted insert and query walk over the bucket memories.
module kmsl_ctrl
  import kmsl_pkg::*;
#(
  parameter int SLOTS_PER_KEY = 16,
  parameter int VALUE_BITS    = 12,
  parameter int CW            = $clog2(SLOTS_PER_KEY + 1),
  parameter int SAW           = $clog2(NUM_KEYS * SLOTS_PER_KEY)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transaction
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_kind,
  input  logic [CHAR_W-1:0]     in_name_char0,
  input  logic [CHAR_W-1:0]     in_name_char1,
  input  logic [CHAR_W-1:0]     in_name_char2,
  input  logic [CHAR_W-1:0]     in_name_char3,
  input  logic [IN_VAL_W-1:0]   in_item_value,
  // result hand-off
  input  logic                  out_free,
  output logic                  res_load,
  output res_t                  res,
  // count memory
  output logic                  cnt_we,
  output logic [KEY_W-1:0]      cnt_waddr,
  output logic [CW-1:0]         cnt_wdata,
  output logic [KEY_W-1:0]      cnt_raddr,
  input  logic [CW-1:0]         cnt_rdata,
  // slot memory
  output logic                  slot_we,
  output logic [SAW-1:0]        slot_waddr,
  output logic [VALUE_BITS-1:0] slot_wdata,
  output logic [SAW-1:0]        slot_raddr,
  input  logic [VALUE_BITS-1:0] slot_rdata
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ACC1    = 4'd2;
  localparam logic [3:0] S_ACC2    = 4'd3;
  localparam logic [3:0] S_ACC3    = 4'd4;
  localparam logic [3:0] S_BASE    = 4'd5;
  localparam logic [3:0] S_CNT     = 4'd6;
  localparam logic [3:0] S_INS_RD  = 4'd7;
  localparam logic [3:0] S_INS_CMP = 4'd8;
  localparam logic [3:0] S_INS_PUT = 4'd9;
  localparam logic [3:0] S_Q_RD    = 4'd10;
  localparam logic [3:0] S_Q_OUT   = 4'd11;
  localparam logic [3:0] S_RESP    = 4'd12;

  localparam logic [CW-1:0]    SLOTS_C   = CW'(SLOTS_PER_KEY);
  localparam logic [KEY_W-1:0] LAST_KEY  = KEY_W'(NUM_KEYS - 1);

  logic [3:0]            state_r, state_nxt;
  logic [KEY_W-1:0]      clr_r, clr_nxt;
  logic                  kind_r, kind_nxt;
  logic [CHAR_W-1:0]     c0_r, c1_r, c2_r, c3_r;
  logic [CHAR_W-1:0]     c0_nxt, c1_nxt, c2_nxt, c3_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SAW-1:0]        base_r, base_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  res_t                  res_r, res_nxt;

  logic                  name_ok;
  logic [CW-1:0]         cnt_rd;
  logic [CW-1:0]         cnt_inc;
  logic [CW-1:0]         rd_off;
  logic                  ins_phase;
  logic [VALUE_BITS+IN_VAL_W-1:0] val_ext;
  logic [VALUE_BITS+OUT_VAL_W-1:0] slot_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_r_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_rd_ext;
  logic [CW+CNT_OUT_W-1:0] cnt_inc_ext;
  logic [CHAR_W-1:0]     d0, d1, d2, d3;

  // value and count width adaptation (zero-extend, then keep the low bits)
  assign val_ext     = {{VALUE_BITS{1'b0}}, in_item_value};
  assign slot_ext    = {{OUT_VAL_W{1'b0}}, slot_rdata};
  assign cnt_r_ext   = {{CNT_OUT_W{1'b0}}, cnt_r};
  assign cnt_rd_ext  = {{CNT_OUT_W{1'b0}}, cnt_rd};
  assign cnt_inc_ext = {{CNT_OUT_W{1'b0}}, cnt_inc};

  assign name_ok = is_letter(c0_r) && is_letter(c1_r) && is_letter(c2_r) && is_digit(c3_r);
  assign d0 = c0_r - CHAR_A;
  assign d1 = c1_r - CHAR_A;
  assign d2 = c2_r - CHAR_A;
  assign d3 = c3_r - CHAR_ZERO;

  assign cnt_rd  = (cnt_rdata > SLOTS_C) ? SLOTS_C : cnt_rdata;
  assign cnt_inc = cnt_r + CW'(1);

  // insert walk reads the slot below the hole; queries read the slot itself
  assign ins_phase  = (state_r == S_INS_RD) || (state_r == S_INS_CMP);
  assign rd_off     = ins_phase ? (idx_r - CW'(1)) : idx_r;
  assign slot_raddr = base_r + SAW'(rd_off);
  assign cnt_raddr  = key_r;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    kind_nxt  = kind_r;
    c0_nxt    = c0_r;
    c1_nxt    = c1_r;
    c2_nxt    = c2_r;
    c3_nxt    = c3_r;
    val_nxt   = val_r;
    key_nxt   = key_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;

    cnt_we     = 1'b0;
    cnt_waddr  = key_r;
    cnt_wdata  = cnt_inc;
    slot_we    = 1'b0;
    slot_waddr = base_r + SAW'(idx_r);
    slot_wdata = val_r;
    res_load   = 1'b0;
    res        = res_r;

    case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        if (clr_r == LAST_KEY) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + KEY_W'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          c0_nxt    = in_name_char0;
          c1_nxt    = in_name_char1;
          c2_nxt    = in_name_char2;
          c3_nxt    = in_name_char3;
          val_nxt   = val_ext[VALUE_BITS-1:0];
          state_nxt = S_ACC1;
        end
      end
      S_ACC1: begin
        if (!name_ok) begin
          res_nxt   = '{key_index: '0, entry_count: '0, value: '0, has_value: 1'b0,
                        last_of_run: 1'b1, status: ST_BAD_NAME};
          state_nxt = S_RESP;
        end else begin
          key_nxt   = KEY_W'(d0) * KEY_W'(RADIX_L) + KEY_W'(d1);
          state_nxt = S_ACC2;
        end
      end
      S_ACC2: begin
        key_nxt   = key_r * KEY_W'(RADIX_L) + KEY_W'(d2);
        state_nxt = S_ACC3;
      end
      S_ACC3: begin
        key_nxt   = key_r * KEY_W'(RADIX_D) + KEY_W'(d3);
        state_nxt = S_BASE;
      end
      S_BASE: begin
        base_nxt  = SAW'(key_r) * SAW'(SLOTS_PER_KEY);
        state_nxt = S_CNT;
      end
      S_CNT: begin
        cnt_nxt = cnt_rd;
        if (!kind_r) begin
          if (cnt_rd >= SLOTS_C) begin
            res_nxt   = '{key_index: key_r, entry_count: cnt_rd_ext[CNT_OUT_W-1:0],
                          value: '0, has_value: 1'b0, last_of_run: 1'b1,
                          status: ST_FULL};
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = cnt_rd;
            state_nxt = (cnt_rd == '0) ? S_INS_PUT : S_INS_RD;
          end
        end else begin
          if (cnt_rd == '0) begin
            res_nxt   = '{key_index: key_r, entry_count: '0, value: '0, has_value: 1'b0,
                          last_of_run: 1'b1, status: ST_OK};
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_Q_RD;
          end
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        // larger neighbor moves up one slot; equal values stay ahead of the new one
        if (slot_rdata > val_r) begin
          slot_we    = 1'b1;
          slot_wdata = slot_rdata;
          idx_nxt    = idx_r - CW'(1);
          state_nxt  = (idx_r == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        slot_we   = 1'b1;
        cnt_we    = 1'b1;
        res_nxt   = '{key_index: key_r, entry_count: cnt_inc_ext[CNT_OUT_W-1:0],
                      value: '0, has_value: 1'b0, last_of_run: 1'b1, status: ST_OK};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_RD: begin
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        res = '{key_index: key_r, entry_count: cnt_r_ext[CNT_OUT_W-1:0],
                value: slot_ext[OUT_VAL_W-1:0], has_value: 1'b1,
                last_of_run: (idx_r + CW'(1) == cnt_r), status: ST_OK};
        if (out_free) begin
          res_load = 1'b1;
          if (idx_r + CW'(1) == cnt_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_Q_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    c0_r   <= c0_nxt;
    c1_r   <= c1_nxt;
    c2_r   <= c2_nxt;
    c3_r   <= c3_nxt;
    val_r  <= val_nxt;
    key_r  <= key_nxt;
    base_r <= base_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    res_r  <= res_nxt;
  end

endmodule

>>> sv/keyed_multimap_sorted_lookup_core.sv
// Paths to out_valid: bad name, full insert or empty query, insert with a read and a compare
//   step per slot compared in the sorted walk, query with one slot read per value returned.
// Flow: one transaction at a time, next accepted the cycle after the last result
//   enters the output register; output stalls delay both the results and the next accept.
// Reset: synchronous, active low; a clear pass then writes all 175760 bucket counts
//   to zero, during which no input transaction is accepted.
module keyed_multimap_sorted_lookup_core
  import kmsl_pkg::*;
#(
  parameter int SLOTS_PER_KEY = 16,
  parameter int VALUE_BITS    = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [CHAR_W-1:0]    in_name_char0,
  input  logic [CHAR_W-1:0]    in_name_char1,
  input  logic [CHAR_W-1:0]    in_name_char2,
  input  logic [CHAR_W-1:0]    in_name_char3,
  input  logic [IN_VAL_W-1:0]  in_item_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_W-1:0]     out_key_index,
  output logic [CNT_OUT_W-1:0] out_entry_count,
  output logic [OUT_VAL_W-1:0] out_value,
  output logic                 out_has_value,
  output logic                 out_last_of_run,
  output logic [STATUS_W-1:0]  out_status
);

  // count memory width holds 0..SLOTS_PER_KEY; slot memory is one row per key
  localparam int CW         = $clog2(SLOTS_PER_KEY + 1);
  localparam int SLOT_DEPTH = NUM_KEYS * SLOTS_PER_KEY;
  localparam int SAW        = $clog2(SLOT_DEPTH);

  logic                  cnt_we;
  logic [KEY_W-1:0]      cnt_waddr;
  logic [CW-1:0]         cnt_wdata;
  logic [KEY_W-1:0]      cnt_raddr;
  logic [CW-1:0]         cnt_rdata;
  logic                  slot_we;
  logic [SAW-1:0]        slot_waddr;
  logic [VALUE_BITS-1:0] slot_wdata;
  logic [SAW-1:0]        slot_raddr;
  logic [VALUE_BITS-1:0] slot_rdata;

  logic                  out_free;
  logic                  res_load;
  res_t                  res;

  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r;

  // Per-key fill counts, cleared by the sequencer's sweep after reset.
  kmsl_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_KEYS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Sorted bucket slots; only slots below a key's count are ever read.
  kmsl_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (SLOT_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  kmsl_ctrl #(
    .SLOTS_PER_KEY (SLOTS_PER_KEY),
    .VALUE_BITS    (VALUE_BITS),
    .CW            (CW),
    .SAW           (SAW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_name_char0 (in_name_char0),
    .in_name_char1 (in_name_char1),
    .in_name_char2 (in_name_char2),
    .in_name_char3 (in_name_char3),
    .in_item_value (in_item_value),
    .out_free      (out_free),
    .res_load      (res_load),
    .res           (res),
    .cnt_we        (cnt_we),
    .cnt_waddr     (cnt_waddr),
    .cnt_wdata     (cnt_wdata),
    .cnt_raddr     (cnt_raddr),
    .cnt_rdata     (cnt_rdata),
    .slot_we       (slot_we),
    .slot_waddr    (slot_waddr),
    .slot_wdata    (slot_wdata),
    .slot_raddr    (slot_raddr),
    .slot_rdata    (slot_rdata)
  );

  // Output register: takes a new result when empty or when the held one leaves.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_index   = out_res_r.key_index;
  assign out_entry_count = out_res_r.entry_count;
  assign out_value       = out_res_r.value;
  assign out_has_value   = out_res_r.has_value;
  assign out_last_of_run = out_res_r.last_of_run;
  assign out_status      = out_res_r.status;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for keyed_multimap_sorted_lookup_core.
module testbench;
  import kmsl_pkg::*;

  // Block configuration; VALUE_BITS equals the input value width, so no masking.
  localparam int SLOTS      = 16;
  localparam int VALUE_BITS = 12;

  // Transaction kinds on in_kind.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Run sizing.
  localparam int N_RANDOM     = 400;
  localparam int POOL_KEYS    = 8;      // small key pool so buckets fill and overflow
  localparam int HOLD_CYCLES  = 300;    // long receiver back-pressure stretch
  localparam int DRAIN_CYCLES = 100;    // longer than the longest query plus stalls
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic                kind;
    logic [CHAR_W-1:0]   c0;
    logic [CHAR_W-1:0]   c1;
    logic [CHAR_W-1:0]   c2;
    logic [CHAR_W-1:0]   c3;
    logic [IN_VAL_W-1:0] val;
  } lookup_op_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_kind       = KIND_INSERT;
  logic [CHAR_W-1:0]    in_name_char0 = '0;
  logic [CHAR_W-1:0]    in_name_char1 = '0;
  logic [CHAR_W-1:0]    in_name_char2 = '0;
  logic [CHAR_W-1:0]    in_name_char3 = '0;
  logic [IN_VAL_W-1:0]  in_item_value = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [KEY_W-1:0]     out_key_index;
  logic [CNT_OUT_W-1:0] out_entry_count;
  logic [OUT_VAL_W-1:0] out_value;
  logic                 out_has_value;
  logic                 out_last_of_run;
  logic [STATUS_W-1:0]  out_status;

  keyed_multimap_sorted_lookup_core #(
    .SLOTS_PER_KEY(SLOTS),
    .VALUE_BITS   (VALUE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_name_char0  (in_name_char0),
    .in_name_char1  (in_name_char1),
    .in_name_char2  (in_name_char2),
    .in_name_char3  (in_name_char3),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_key_index  (out_key_index),
    .out_entry_count(out_entry_count),
    .out_value      (out_value),
    .out_has_value  (out_has_value),
    .out_last_of_run(out_last_of_run),
    .out_status     (out_status)
  );

  // 12-unit clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow multimap: per-key fill level and sorted slots, keyed sparsely.
  // Only slots below a bucket's fill level are ever read, and those exist.
  // ---------------------------------------------------------------------------
  int                   bucket_fill [int];
  logic [OUT_VAL_W-1:0] slot_store  [int];
  res_t                 owed_records[$];   // results the block still owes, oldest first
  lookup_op_t           ops_pending [$];   // transactions not yet offered
  lookup_op_t           on_wire;           // transaction currently offered

  int n_total     = 0;
  int n_presented = 0;   // updated with NBAs, read by other processes
  int n_accepted  = 0;
  int n_results   = 0;
  int n_errors    = 0;
  int n_kept      = 0;
  int n_dropped   = 0;
  int n_bad_names = 0;
  int n_read_back = 0;
  int cycle_cnt   = 0;

  // Appends one owed result at the tail of the expected queue.
  function automatic void owe_record(input res_t rec);
    owed_records.insert(owed_records.size(), rec);
  endfunction

  // Appends one transaction at the tail of the stimulus queue.
  function automatic void queue_op(input lookup_op_t op);
    ops_pending.insert(ops_pending.size(), op);
  endfunction

  function automatic bit in_span(logic [CHAR_W-1:0] c, logic [CHAR_W-1:0] lo, int span);
    return (c >= lo) && (int'(c) < int'(lo) + span);
  endfunction

  function automatic bit name_ok(lookup_op_t op);
    return in_span(op.c0, CHAR_A, RADIX_L) && in_span(op.c1, CHAR_A, RADIX_L) &&
           in_span(op.c2, CHAR_A, RADIX_L) && in_span(op.c3, CHAR_ZERO, RADIX_D);
  endfunction

  // Applies one accepted transaction to the shadow multimap and queues the
  // results the block must produce for it.
  task automatic bucket_apply(input lookup_op_t op);
    res_t                 rec;
    int                   key;
    int                   cnt;
    int                   base;
    int                   i;
    logic [OUT_VAL_W-1:0] v;
    rec = '0;
    rec.last_of_run = 1'b1;
    if (!name_ok(op)) begin
      // Bad character anywhere: state untouched, zeroed record with status.
      rec.status = ST_BAD_NAME;
      owe_record(rec);
      n_bad_names++;
      return;
    end
    key = ((((int'(op.c0) - int'(CHAR_A)) * RADIX_L + (int'(op.c1) - int'(CHAR_A)))
           * RADIX_L + (int'(op.c2) - int'(CHAR_A))) * RADIX_D)
          + (int'(op.c3) - int'(CHAR_ZERO));
    cnt  = bucket_fill.exists(key) ? bucket_fill[key] : 0;
    base = key * SLOTS;
    rec.key_index = KEY_W'(key);
    if (op.kind == KIND_INSERT) begin
      if (cnt >= SLOTS) begin
        rec.entry_count = CNT_OUT_W'(SLOTS);
        rec.status      = ST_FULL;
        n_dropped++;
      end else begin
        // Insertion sort step; an equal value lands after the existing ones.
        v = op.val;
        i = cnt;
        while (i > 0 && slot_store[base + i - 1] > v) begin
          slot_store[base + i] = slot_store[base + i - 1];
          i--;
        end
        slot_store[base + i] = v;
        cnt++;
        bucket_fill[key] = cnt;
        rec.entry_count  = CNT_OUT_W'(cnt);
        n_kept++;
      end
      owe_record(rec);
    end else if (cnt == 0) begin
      owe_record(rec);                      // empty bucket: single bare record
    end else begin
      for (i = 0; i < cnt; i++) begin
        rec.entry_count = CNT_OUT_W'(cnt);
        rec.value       = slot_store[base + i];
        rec.has_value   = 1'b1;
        rec.last_of_run = (i == cnt - 1);
        owe_record(rec);
        n_read_back++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic lookup_op_t named_op(logic kind, int key, logic [IN_VAL_W-1:0] v);
    lookup_op_t op;
    int         k;
    k       = key;
    op.kind = kind;
    op.val  = v;
    op.c3   = CHAR_ZERO + CHAR_W'(k % RADIX_D);
    k       = k / RADIX_D;
    op.c2   = CHAR_A + CHAR_W'(k % RADIX_L);
    k       = k / RADIX_L;
    op.c1   = CHAR_A + CHAR_W'(k % RADIX_L);
    k       = k / RADIX_L;
    op.c0   = CHAR_A + CHAR_W'(k);
    return op;
  endfunction

  function automatic logic [CHAR_W-1:0] non_letter();
    if ($urandom_range(0, 1)) return CHAR_W'($urandom_range(0, int'(CHAR_A) - 1));
    return CHAR_W'($urandom_range(int'(CHAR_A) + RADIX_L, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] non_digit();
    if ($urandom_range(0, 1)) return CHAR_W'($urandom_range(0, int'(CHAR_ZERO) - 1));
    return CHAR_W'($urandom_range(int'(CHAR_ZERO) + RADIX_D, 255));
  endfunction

  // Half: a real name with one character broken. Half: raw bytes, forced bad.
  function automatic lookup_op_t bad_name_op(logic kind);
    lookup_op_t op;
    if ($urandom_range(0, 1)) begin
      op = named_op(kind, $urandom_range(0, NUM_KEYS - 1), IN_VAL_W'($urandom));
      case ($urandom_range(0, 3))
        0: op.c0 = non_letter();
        1: op.c1 = non_letter();
        2: op.c2 = non_letter();
        default: op.c3 = non_digit();
      endcase
    end else begin
      op.kind = kind;
      op.val  = IN_VAL_W'($urandom);
      op.c0   = CHAR_W'($urandom);
      op.c1   = CHAR_W'($urandom);
      op.c2   = CHAR_W'($urandom);
      op.c3   = CHAR_W'($urandom);
      if (name_ok(op)) op.c3 = non_digit();
    end
    return op;
  endfunction

  // Idle mix per third of the run: sender 6% / receiver 45%, swapped, then none.
  function automatic int run_third();
    if (n_presented < n_total / 3) return 0;
    if (n_presented < 2 * n_total / 3) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (run_third())
      0: return 6;
      1: return 45;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (run_third())
      0: return 45;
      1: return 6;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: the transaction on the wire is taken at an edge with valid high and
  // stall low; the next one (or an idle) is put up at that same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    lookup_op_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        bucket_apply(on_wire);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (ops_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          nxt            = ops_pending.pop_front();
          on_wire        = nxt;
          in_valid      <= 1'b1;
          in_kind       <= nxt.kind;
          in_name_char0 <= nxt.c0;
          in_name_char1 <= nxt.c1;
          in_name_char2 <= nxt.c2;
          in_name_char3 <= nxt.c3;
          in_item_value <= nxt.val;
          n_presented   <= n_presented + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: random per third of the run, plus one long hold-off early
  // in the last third so the block backs up and stalls its input while the
  // sender keeps offering.
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  bit hold_fired = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_fired && n_accepted >= 2 * n_total / 3 + 10) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transaction is checked against the oldest owed record.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      n_results++;
      if (owed_records.size() == 0) begin
        if (n_errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got key %0d count %0d value %0d",
                   $time, out_key_index, out_entry_count, out_value);
        n_errors++;
      end else begin
        want = owed_records.pop_front();
        check_field("key_index",   32'(want.key_index),   32'(out_key_index));
        check_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
        check_field("out_value",   32'(want.value),       32'(out_value));
        check_field("has_value",   32'(want.has_value),   32'(out_has_value));
        check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
        check_field("status",      32'(want.status),      32'(out_status));
      end
    end
  end

  // Watchdog; the bucket-count clear pass after reset counts toward its limit.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_cnt,
               owed_records.size());
      $display("keyed_multimap_sorted_lookup_core verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    lookup_op_t op;
    int         pool[POOL_KEYS];
    int         r;
    int         n;

    // Directed: lowest and highest keys, duplicates, shifts, empty bucket,
    // and every bad-character boundary on both sides of each range.
    queue_op(named_op(KIND_INSERT, 0, 12'd0));
    queue_op(named_op(KIND_INSERT, 0, 12'hFFF));
    queue_op(named_op(KIND_INSERT, 0, 12'hFFF));      // duplicate kept
    queue_op(named_op(KIND_INSERT, 0, 12'h800));      // shifts two up
    queue_op(named_op(KIND_INSERT, 0, 12'd0));        // lands after the 0
    queue_op(named_op(KIND_QUERY, 0, 12'hABC));
    queue_op(named_op(KIND_QUERY, NUM_KEYS - 1, 12'd0)); // empty bucket
    queue_op(named_op(KIND_INSERT, NUM_KEYS - 1, 12'hFFF));
    queue_op(named_op(KIND_INSERT, NUM_KEYS - 1, 12'd1));
    queue_op(named_op(KIND_QUERY, NUM_KEYS - 1, 12'h555));
    op = named_op(KIND_INSERT, 0, 12'd9);  op.c0 = CHAR_A - 8'd1;
    queue_op(op);
    op = named_op(KIND_INSERT, 0, 12'd9);  op.c1 = CHAR_A + CHAR_W'(RADIX_L);
    queue_op(op);
    op = named_op(KIND_QUERY, 0, 12'd0);   op.c2 = 8'hFF;
    queue_op(op);
    op = named_op(KIND_INSERT, 0, 12'd9);  op.c0 = 8'h00;
    queue_op(op);
    op = named_op(KIND_INSERT, 0, 12'd9);  op.c3 = CHAR_ZERO - 8'd1;
    queue_op(op);
    op = named_op(KIND_QUERY, 0, 12'd0);   op.c3 = CHAR_ZERO + CHAR_W'(RADIX_D);
    queue_op(op);
    op = named_op(KIND_INSERT, NUM_KEYS - 1, 12'd3);  op.c2 = CHAR_A + 8'd32; // lower case
    queue_op(op);
    queue_op(named_op(KIND_QUERY, 0, 12'd0));         // unchanged by rejects

    // Random: mostly traffic on a few hot keys so buckets fill up and
    // overflow, with scattered keys and broken names mixed in.
    pool[0] = 0;
    pool[1] = NUM_KEYS - 1;
    for (n = 2; n < POOL_KEYS; n++) pool[n] = $urandom_range(0, NUM_KEYS - 1);
    for (n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op = bad_name_op(1'($urandom_range(0, 1)));
      end else if (r < 20) begin
        op = named_op(1'($urandom_range(0, 1)), $urandom_range(0, NUM_KEYS - 1),
                      IN_VAL_W'($urandom));
      end else begin
        op = named_op($urandom_range(0, 99) < 60 ? KIND_INSERT : KIND_QUERY,
                      pool[$urandom_range(0, POOL_KEYS - 1)],
                      $urandom_range(0, 1) ? IN_VAL_W'($urandom_range(0, 15))
                                           : IN_VAL_W'($urandom));
      end
      queue_op(op);
    end
    n_total = ops_pending.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Sampled on the falling edge to stay clear of the driver's updates.
    while (ops_pending.size() != 0 || in_valid) @(negedge clk);
    while (owed_records.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run: %0d transactions in (%0d inserts kept, %0d dropped on full bucket,",
             n_accepted, n_kept, n_dropped);
    $display("  %0d bad names), %0d results out, %0d stored values read back in order",
             n_bad_names, n_results, n_read_back);
    if (n_errors == 0 && owed_records.size() == 0) begin
      $display("keyed_multimap_sorted_lookup_core verification clean");
    end else begin
      $display("keyed_multimap_sorted_lookup_core verification failed");
    end
    $finish;
  end

endmodule
